### src/i2cds_pkg.sv
// Package for the bus clock divider search unit.
// Holds field widths, search constants and the sideband types of the pipeline.
// No dependencies.
package i2cds_pkg;

    localparam int CLK_W      = 30;
    localparam int TGT_W      = 24;
    localparam int DIV_W      = 8;
    localparam int SEL_W      = 2;
    localparam int HZ_W       = 26;
    localparam int NUM_PS     = 4;
    localparam int NUM_W      = 31;
    localparam int DEN_W      = 32;
    localparam int DQ_W       = DIV_W + 1;
    localparam int SCL_DIV_W  = 15;
    localparam int BASE_SHIFT = 4;
    localparam logic [DIV_W-1:0] DIV_MAX = 8'd255;

    // Sideband that rides along with the divider computation.
    typedef struct packed {
        logic [CLK_W-1:0] core;
        logic [TGT_W-1:0] target;
        logic             search;
        logic [HZ_W-1:0]  base_hz;
        logic [HZ_W-1:0]  base_err;
    } side1_t;

    // Sideband that rides along with the achieved clock computation.
    typedef struct packed {
        logic [TGT_W-1:0]                  target;
        logic                              search;
        logic [HZ_W-1:0]                   base_hz;
        logic [HZ_W-1:0]                   base_err;
        logic [NUM_PS-1:0][DIV_W-1:0]      divs;
    } side2_t;

endpackage

### src/i2cds_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage, several lanes.
// Lanes share one valid bit and one sideband word. No package dependencies.
module i2cds_div_pipe #(
    parameter int LANES = 4,
    parameter int NW    = 31,
    parameter int DW    = 32,
    parameter int QW    = 9,
    parameter int SW    = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [LANES-1:0][NW-1:0]    num,
    input  logic [LANES-1:0][DW-1:0]    den,
    input  logic [SW-1:0]               side_in,
    output logic                        out_valid,
    output logic [LANES-1:0][QW-1:0]    quot,
    output logic [SW-1:0]               side_out
);

    localparam int CW = (NW > DW) ? NW : DW;

    logic                      valid_reg [0:QW];
    logic [LANES-1:0][NW-1:0]  rem_reg   [0:QW];
    logic [LANES-1:0][DW-1:0]  den_reg   [0:QW];
    logic [LANES-1:0][QW-1:0]  quot_reg  [0:QW];
    logic [SW-1:0]             side_reg  [0:QW];

    // Entry stage captures the operands.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num;
            den_reg[0]  <= den;
            quot_reg[0] <= '0;
            side_reg[0] <= side_in;
        end
    end

    // Each stage decides one quotient bit, most significant first.
    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        localparam int B = QW - 1 - s;

        logic [LANES-1:0][NW-1:0] rem_next;
        logic [LANES-1:0][QW-1:0] quot_next;

        always_comb
        begin
            logic [NW-1:0] shifted;
            logic [CW-1:0] diff;
            logic          ge;
            for (int l = 0; l < LANES; l++)
            begin
                shifted = rem_reg[s][l] >> B;
                ge      = CW'(den_reg[s][l]) <= CW'(shifted);
                diff    = CW'(rem_reg[s][l]) - (CW'(den_reg[s][l]) << B);
                rem_next[l]  = ge ? diff[NW-1:0] : rem_reg[s][l];
                quot_next[l] = quot_reg[s][l] | (ge ? (QW'(1) << B) : QW'(0));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s+1] <= valid_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1]  <= rem_next;
                den_reg[s+1]  <= den_reg[s];
                quot_reg[s+1] <= quot_next;
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = valid_reg[QW];
    assign quot      = quot_reg[QW];
    assign side_out  = side_reg[QW];

endmodule

### src/i2c_clock_divider_search_unit.sv
// Top level of the bus clock divider search unit.
// Depends on i2cds_pkg and i2cds_div_pipe.
//
// The unit takes one request per cycle unless the output stalls, and returns one result
// per request, in order. A request passes a 10-stage divider for the bit-rate divider of
// all four prescalers in parallel, a 27-stage divider for the achieved clock, an error
// stage and the output register. The pipeline moves as one; while a result waits at the
// output with stall high, all stages hold and the input stalls, so nothing is lost or
// repeated.
module i2c_clock_divider_search_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [i2cds_pkg::CLK_W-1:0]     core_clock_hz,
    input  logic [i2cds_pkg::TGT_W-1:0]     target_bus_hz,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [i2cds_pkg::DIV_W-1:0]     bit_rate_divider,
    output logic [i2cds_pkg::SEL_W-1:0]     prescale_select,
    output logic [i2cds_pkg::HZ_W-1:0]      achieved_hz,
    output logic [i2cds_pkg::HZ_W-1:0]      error_hz
);

    import i2cds_pkg::*;

    logic en;

    // Front end: numerators, denominators and the starting choice.
    logic [NUM_PS-1:0][NUM_W-1:0] num1;
    logic [NUM_PS-1:0][DEN_W-1:0] den1;
    side1_t                       side1_in;
    side1_t                       side1_out;
    logic                         d1_valid;
    logic [NUM_PS-1:0][DQ_W-1:0]  d1_quot;

    // Achieved clock dividers.
    logic [NUM_PS-1:0][CLK_W-1:0]     num2;
    logic [NUM_PS-1:0][SCL_DIV_W-1:0] den2;
    side2_t                           side2_in;
    side2_t                           side2_out;
    logic                             d2_valid;
    logic [NUM_PS-1:0][HZ_W-1:0]      d2_quot;

    // Error stage.
    logic                         err_valid_reg;
    logic [NUM_PS-1:0][HZ_W-1:0]  freq_reg;
    logic [NUM_PS-1:0][HZ_W-1:0]  err_reg;
    side2_t                       side_e_reg;
    logic [NUM_PS-1:0][HZ_W-1:0]  err_next;

    // Output stage.
    logic             out_valid_reg;
    logic [DIV_W-1:0] div_reg;
    logic [SEL_W-1:0] sel_reg;
    logic [HZ_W-1:0]  hz_reg;
    logic [HZ_W-1:0]  herr_reg;
    logic [DIV_W-1:0] div_next;
    logic [SEL_W-1:0] sel_next;
    logic [HZ_W-1:0]  hz_next;
    logic [HZ_W-1:0]  herr_next;

    // The whole pipeline advances unless a result is held at the output.
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // Rounded divider numerator f - 16t + p*t over denominator 2*p*t.
    always_comb
    begin
        logic [HZ_W-1:0] base;
        base = core_clock_hz[CLK_W-1:BASE_SHIFT];
        for (int k = 0; k < NUM_PS; k++)
        begin
            num1[k] = NUM_W'(core_clock_hz) - (NUM_W'(target_bus_hz) << BASE_SHIFT)
                      + (NUM_W'(target_bus_hz) << (2 * k));
            den1[k] = DEN_W'(target_bus_hz) << (2 * k + 1);
        end
        side1_in.core     = core_clock_hz;
        side1_in.target   = target_bus_hz;
        side1_in.search   = (target_bus_hz != '0) &&
                            (CLK_W'(core_clock_hz) >= (CLK_W'(target_bus_hz) << BASE_SHIFT));
        side1_in.base_hz  = base;
        side1_in.base_err = (base > HZ_W'(target_bus_hz)) ? (base - HZ_W'(target_bus_hz))
                                                          : (HZ_W'(target_bus_hz) - base);
    end

    i2cds_div_pipe #(
        .LANES (NUM_PS),
        .NW    (NUM_W),
        .DW    (DEN_W),
        .QW    (DQ_W),
        .SW    ($bits(side1_t))
    ) u_div_rate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .num       (num1),
        .den       (den1),
        .side_in   (side1_in),
        .out_valid (d1_valid),
        .quot      (d1_quot),
        .side_out  (side1_out)
    );

    // Clamp the divider and form the bus clock divisor 16 + 2*d*p.
    always_comb
    begin
        logic [DIV_W-1:0] d;
        for (int k = 0; k < NUM_PS; k++)
        begin
            d = d1_quot[k][DQ_W-1] ? DIV_MAX : d1_quot[k][DIV_W-1:0];
            side2_in.divs[k] = d;
            num2[k] = side1_out.core;
            den2[k] = SCL_DIV_W'(16) + (SCL_DIV_W'(d) << (2 * k + 1));
        end
        side2_in.target   = side1_out.target;
        side2_in.search   = side1_out.search;
        side2_in.base_hz  = side1_out.base_hz;
        side2_in.base_err = side1_out.base_err;
    end

    i2cds_div_pipe #(
        .LANES (NUM_PS),
        .NW    (CLK_W),
        .DW    (SCL_DIV_W),
        .QW    (HZ_W),
        .SW    ($bits(side2_t))
    ) u_div_clk (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d1_valid),
        .num       (num2),
        .den       (den2),
        .side_in   (side2_in),
        .out_valid (d2_valid),
        .quot      (d2_quot),
        .side_out  (side2_out)
    );

    // Absolute error of each candidate.
    always_comb
    begin
        for (int k = 0; k < NUM_PS; k++)
        begin
            err_next[k] = (d2_quot[k] > HZ_W'(side2_out.target))
                          ? (d2_quot[k] - HZ_W'(side2_out.target))
                          : (HZ_W'(side2_out.target) - d2_quot[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            err_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            freq_reg   <= d2_quot;
            err_reg    <= err_next;
            side_e_reg <= side2_out;
        end
    end

    // Smallest error of f/16 and, if searching, each candidate; ties keep the earlier one.
    always_comb
    begin
        div_next  = '0;
        sel_next  = '0;
        hz_next   = side_e_reg.base_hz;
        herr_next = side_e_reg.base_err;
        for (int k = 0; k < NUM_PS; k++)
        begin
            if (side_e_reg.search && (err_reg[k] < herr_next))
            begin
                div_next  = side_e_reg.divs[k];
                sel_next  = SEL_W'(k);
                hz_next   = freq_reg[k];
                herr_next = err_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= err_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg  <= div_next;
            sel_reg  <= sel_next;
            hz_reg   <= hz_next;
            herr_reg <= herr_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign bit_rate_divider = div_reg;
    assign prescale_select  = sel_reg;
    assign achieved_hz      = hz_reg;
    assign error_hz         = herr_reg;

endmodule

### verif/i2c_clock_divider_search_unit_tb.sv
// Testbench for the bus clock divider search unit.
// Depends on i2cds_pkg and i2c_clock_divider_search_unit; checks every result
// against a behavioral divider search under random valid and stall pressure.
module i2c_clock_divider_search_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cds_pkg::*;

    typedef struct packed {
        logic [CLK_W-1:0] core;
        logic [TGT_W-1:0] target;
    } request_t;

    typedef struct packed {
        logic [DIV_W-1:0] div;
        logic [SEL_W-1:0] sel;
        logic [HZ_W-1:0]  hz;
        logic [HZ_W-1:0]  err;
    } setting_t;

    localparam int PIPE_LATENCY = 39;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [CLK_W-1:0]    core_clock_hz;
    logic [TGT_W-1:0]    target_bus_hz;
    logic                out_valid;
    logic                out_stall;
    logic [DIV_W-1:0]    bit_rate_divider;
    logic [SEL_W-1:0]    prescale_select;
    logic [HZ_W-1:0]     achieved_hz;
    logic [HZ_W-1:0]     error_hz;

    request_t pending_requests[$];
    setting_t expected_settings[$];
    int       mismatch_count;
    bit       hold_sender;
    bit       hold_receiver;
    int       burst_left;
    int       gap_left;
    int       stall_phase;

    i2c_clock_divider_search_unit DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .core_clock_hz    (core_clock_hz),
        .target_bus_hz    (target_bus_hz),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .bit_rate_divider (bit_rate_divider),
        .prescale_select  (prescale_select),
        .achieved_hz      (achieved_hz),
        .error_hz         (error_hz)
    );

    // Search over the four prescalers for the divider closest to the target.
    function automatic setting_t search_divider(request_t req);
        longint unsigned f;
        longint unsigned t;
        longint unsigned p;
        longint unsigned den;
        longint unsigned d;
        longint unsigned hz;
        longint unsigned err;
        longint unsigned best_hz;
        longint unsigned best_err;
        setting_t best;
        f = req.core;
        t = req.target;
        best_hz = f / 16;
        best_err = (best_hz > t) ? best_hz - t : t - best_hz;
        best.div = '0;
        best.sel = '0;
        for (int k = 0; k < NUM_PS; k++)
        begin
            p = 64'd1 << (2 * k);
            if (t == 0 || f < 16 * t)
                continue;
            den = 2 * p * t;
            d = (f - 16 * t + den / 2) / den;
            if (d > 255)
                d = 255;
            hz = f / (16 + 2 * d * p);
            err = (hz > t) ? hz - t : t - hz;
            if (err < best_err)
            begin
                best.div = d[DIV_W-1:0];
                best.sel = k[SEL_W-1:0];
                best_hz = hz;
                best_err = err;
            end
        end
        best.hz = best_hz[HZ_W-1:0];
        best.err = best_err[HZ_W-1:0];
        return best;
    endfunction

    // Clock and reset.
    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: offers queued requests in bursts separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            core_clock_hz <= '0;
            target_bus_hz <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            // The previous transfer completed or nothing was offered.
            if (in_valid)
            begin
                expected_settings.push_back(search_divider({core_clock_hz, target_bus_hz}));
                void'(pending_requests.pop_front());
            end
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (hold_sender || pending_requests.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                request_t nxt;
                nxt = pending_requests[0];
                in_valid <= 1'b1;
                core_clock_hz <= nxt.core;
                target_bus_hz <= nxt.target;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(40, 1);
                    gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
                end
            end
        end
    end

    // Receiver stall pattern plus an optional long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 300;
            if (hold_receiver)
                out_stall <= 1'b1;
            else if (stall_phase < 100)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(2, 0) == 0);
        end
    end

    // Monitor: compares each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            setting_t got;
            setting_t exp_s;
            got = {bit_rate_divider, prescale_select, achieved_hz, error_hz};
            if (expected_settings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                exp_s = expected_settings.pop_front();
                if (got !== exp_s)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: div %0d/%0d sel %0d/%0d hz %0d/%0d err %0d/%0d",
                                 exp_s.div, got.div, exp_s.sel, got.sel,
                                 exp_s.hz, got.hz, exp_s.err, got.err);
                end
            end
        end
    end

    // Adds one request with the given fields.
    task automatic queue_request(longint unsigned f, longint unsigned t);
        request_t r;
        r.core = f[CLK_W-1:0];
        r.target = t[TGT_W-1:0];
        pending_requests.push_back(r);
    endtask

    // Waits until every queued request has been sent and answered.
    task automatic drain_all();
        while (pending_requests.size() != 0 || expected_settings.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    // Stimulus.
    initial
    begin
        longint unsigned f;
        longint unsigned t;
        mismatch_count = 0;
        hold_sender = 0;
        hold_receiver = 0;
        // Directed: field extremes, zero target, target too high, clamp, tie cases.
        queue_request(1, 0);
        queue_request(30'h3FFFFFFF, 0);
        queue_request(1, 1);
        queue_request(16, 1);
        queue_request(30'h3FFFFFFF, 24'hFFFFFF);
        queue_request(30'h3FFFFFFF, 1);
        queue_request(30'h3FFFFFFF, 67108863);
        queue_request(16000000, 100000);
        queue_request(16000000, 400000);
        queue_request(8000000, 100000);
        queue_request(20000000, 1000);
        queue_request(1000000, 62500);
        queue_request(1000000, 62501);
        queue_request(30'h2AAAAAAA, 24'h555555);
        queue_request(30'h15555555, 24'hAAAAAA);
        queue_request(1073741823, 16777215);
        queue_request(100, 3);
        queue_request(255, 16);
        queue_request(16777215 * 16, 16777215);
        queue_request(500000000, 10);
        drain_all();

        // Long receiver hold-off while the sender keeps offering.
        for (int i = 0; i < 120; i++)
            queue_request($urandom_range(1073741823, 1), $urandom_range(2000000, 0));
        hold_receiver = 1;
        repeat (150) @(posedge clk);
        hold_receiver = 0;
        drain_all();

        // Random part: mostly realistic clocks and targets, some full-range noise.
        for (int i = 0; i < 580; i++)
        begin
            case ($urandom_range(5, 0))
                0: begin f = $urandom_range(1073741823, 1); t = $urandom_range(16777215, 0); end
                1: begin f = $urandom_range(1073741823, 1); t = f / 16 + $urandom_range(3, 0); end
                2: begin f = $urandom_range(50000000, 1000); t = $urandom_range(500, 0); end
                default: begin
                    f = $urandom_range(1073741823, 1000000);
                    t = $urandom_range(1000000, 1);
                end
            endcase
            queue_request(f, t);
            if (i == 300)
            begin
                // Sender pauses until everything already sent has come back.
                hold_sender = 1;
                while (expected_settings.size() != 0 || in_valid)
                    @(posedge clk);
                hold_sender = 0;
            end
        end
        drain_all();
        repeat (PIPE_LATENCY + 10) @(posedge clk);
        if (mismatch_count == 0 && expected_settings.size() == 0)
            $display("i2c_clock_divider_search_unit verification clean");
        else
            $display("i2c_clock_divider_search_unit verification failed");
        $finish;
    end

    // Timeout.
    initial
    begin
        #5ms;
        $display("i2c_clock_divider_search_unit verification failed");
        $finish;
    end
endmodule
